// File: rtl/tbsl_pkg.sv
// tbsl_pkg: widths, constants, band codes and the controller/datapath bundles
// for the three band spectrum level unit
// depends on nothing; used by every module of the unit by scoped names
`default_nettype none

package tbsl_pkg;

    // field and state widths
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int LEVEL_W   = 13;
    localparam int BAR_W     = 9;
    localparam int POS_W     = 8;
    localparam int CNT_W     = 7;
    localparam int ROOT_W    = 18;
    localparam int RAD_W     = SUM_W + 12;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int STEP_W    = 5;

    // iteration counts of the shared divide and root unit
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;

    // bar count limits and reset value
    localparam logic [BAR_W-1:0] MIN_BARS        = BAR_W'(3);
    localparam logic [BAR_W-1:0] MAX_BARS        = BAR_W'(256);
    localparam logic [BAR_W-1:0] BAR_COUNT_RESET = BAR_W'(24);

    // fixed point constants
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(4096);
    localparam logic [9:0]         RECIP3    = 10'd683;    // 2^11 / 3, rounded up
    localparam logic [15:0]        RECIP10   = 16'd52429;  // 2^19 / 10, rounded up

    typedef enum logic [1:0] {
        BAND_BASS,
        BAND_MID,
        BAND_TREBLE
    } band_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic  acc_en;
        logic  div_load;
        logic  div_step;
        logic  sqrt_load;
        logic  sqrt_step;
        logic  scale_en;
        logic  clear_sums;
        band_t band;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_bar;
    } status_t;

    // floor(x / 3) for x up to 512, by reciprocal multiply
    function automatic logic [POS_W-1:0] third(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'(RECIP3);
        return prod[18:11];
    endfunction

    // band sum plus one sample, saturating at the sum width
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]    s,
                                                 input logic [SAMPLE_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(v);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/tbsl_ctrl.sv
// tbsl_ctrl: sequencer for bar accumulation and the per band divide, root
// and scale passes; owns the input ready and the result valid
// depends on tbsl_pkg
`default_nettype none

module tbsl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire tbsl_pkg::status_t status,
    output tbsl_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_SCALE
    } state_t;

    localparam logic [tbsl_pkg::STEP_W-1:0] DIV_LAST  =
        tbsl_pkg::STEP_W'(tbsl_pkg::DIV_STEPS - 1);
    localparam logic [tbsl_pkg::STEP_W-1:0] SQRT_LAST =
        tbsl_pkg::STEP_W'(tbsl_pkg::SQRT_STEPS - 1);

    state_t                        state_reg;
    tbsl_pkg::band_t               band_reg;
    logic [tbsl_pkg::STEP_W-1:0]   step_reg;
    logic                          out_valid_reg;
    logic                          accept;
    tbsl_pkg::band_t               band_after;

    // the last bar of a frame waits until the previous result is taken
    assign s_ready = (state_reg == ST_ACCUM) && !(out_valid_reg && status.last_bar);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    // band order through the shared unit
    always_comb begin
        case (band_reg)
            tbsl_pkg::BAND_BASS: band_after = tbsl_pkg::BAND_MID;
            tbsl_pkg::BAND_MID:  band_after = tbsl_pkg::BAND_TREBLE;
            default:             band_after = tbsl_pkg::BAND_BASS;
        endcase
    end

    // datapath commands decoded from the state
    always_comb begin
        cmd.acc_en     = accept;
        cmd.div_load   = (state_reg == ST_DIV_LOAD);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.sqrt_load  = (state_reg == ST_SQRT_LOAD);
        cmd.sqrt_step  = (state_reg == ST_SQRT);
        cmd.scale_en   = (state_reg == ST_SCALE);
        cmd.clear_sums = (state_reg == ST_SCALE) && (band_reg == tbsl_pkg::BAND_TREBLE);
        cmd.band       = band_reg;
    end

    // state, band, step counter and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            band_reg      <= tbsl_pkg::BAND_BASS;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_ACCUM: begin
                    if (accept && status.last_bar) begin
                        state_reg <= ST_DIV_LOAD;
                        band_reg  <= tbsl_pkg::BAND_BASS;
                    end
                end
                ST_DIV_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (step_reg == DIV_LAST) begin
                        state_reg <= ST_SQRT_LOAD;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQRT_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (step_reg == SQRT_LAST) begin
                        state_reg <= ST_SCALE;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SCALE: begin
                    band_reg <= band_after;
                    if (band_reg == tbsl_pkg::BAND_TREBLE) begin
                        state_reg     <= ST_ACCUM;
                        out_valid_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_DIV_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_ACCUM;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/tbsl_datapath.sv
// tbsl_datapath: bar count register, bar position, band sums, shared
// restoring divider, digit by digit square root, scaling and result registers
// depends on tbsl_pkg
`default_nettype none

module tbsl_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tbsl_pkg::BAR_W-1:0]        cfg_wr_data,
    input  wire logic [tbsl_pkg::SAMPLE_W-1:0]     s_bar_value,
    input  wire tbsl_pkg::cmd_t                    cmd,
    output tbsl_pkg::status_t                      status,
    output logic [tbsl_pkg::LEVEL_W-1:0]           m_bass_level,
    output logic [tbsl_pkg::LEVEL_W-1:0]           m_mid_level,
    output logic [tbsl_pkg::LEVEL_W-1:0]           m_treble_level
);

    logic [tbsl_pkg::BAR_W-1:0]   bar_count_reg;
    logic [tbsl_pkg::BAR_W-1:0]   bars;
    logic [tbsl_pkg::POS_W-1:0]   bass_limit;
    logic [tbsl_pkg::POS_W-1:0]   mid_end;
    logic [tbsl_pkg::CNT_W-1:0]   bass_cnt;
    logic [tbsl_pkg::CNT_W-1:0]   mid_cnt;
    logic [tbsl_pkg::CNT_W-1:0]   treble_cnt;
    logic [tbsl_pkg::POS_W-1:0]   pos_reg;
    logic                         last_bar;
    logic [tbsl_pkg::SUM_W-1:0]   low_sum_reg;
    logic [tbsl_pkg::SUM_W-1:0]   mid_sum_reg;
    logic [tbsl_pkg::SUM_W-1:0]   high_sum_reg;
    logic [tbsl_pkg::SUM_W-1:0]   sel_sum;
    logic [tbsl_pkg::CNT_W-1:0]   sel_cnt;
    logic [tbsl_pkg::SUM_W-1:0]   quo_reg;
    logic [tbsl_pkg::CNT_W-1:0]   drem_reg;
    logic [tbsl_pkg::CNT_W:0]     div_trial;
    logic [tbsl_pkg::RAD_W-1:0]   rad_reg;
    logic [tbsl_pkg::ROOT_W-1:0]  root_reg;
    logic [tbsl_pkg::SREM_W-1:0]  srem_reg;
    logic [tbsl_pkg::SREM_W+1:0]  sqrt_cur;
    logic [tbsl_pkg::SREM_W+1:0]  sqrt_trial;
    logic [tbsl_pkg::LEVEL_W-1:0] root_sat;
    logic [15:0]                  gain_prod;
    logic [31:0]                  tenth_prod;
    logic [tbsl_pkg::LEVEL_W-1:0] scaled;
    logic [tbsl_pkg::LEVEL_W-1:0] level;

    // bar count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_count_reg <= tbsl_pkg::BAR_COUNT_RESET;
        end else if (cfg_wr_en) begin
            bar_count_reg <= cfg_wr_data;
        end
    end

    // effective bar count, band edges and band sizes
    always_comb begin
        if (bar_count_reg < tbsl_pkg::MIN_BARS) begin
            bars = tbsl_pkg::MIN_BARS;
        end else if (bar_count_reg > tbsl_pkg::MAX_BARS) begin
            bars = tbsl_pkg::MAX_BARS;
        end else begin
            bars = bar_count_reg;
        end
        bass_limit = tbsl_pkg::third({1'b0, bars});
        mid_end    = tbsl_pkg::third({bars, 1'b0});
        bass_cnt   = bass_limit[tbsl_pkg::CNT_W-1:0];
        mid_cnt    = tbsl_pkg::CNT_W'(mid_end - bass_limit);
        treble_cnt = tbsl_pkg::CNT_W'(bars - {1'b0, mid_end});
    end

    // a frame ends once the position reaches the last bar of the current count
    assign last_bar        = ({1'b0, pos_reg} + 1'b1) >= bars;
    assign status.last_bar = last_bar;

    // bar position within the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.acc_en) begin
            pos_reg <= last_bar ? '0 : pos_reg + 1'b1;
        end
    end

    // saturating band sums
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_sums) begin
            low_sum_reg  <= '0;
            mid_sum_reg  <= '0;
            high_sum_reg <= '0;
        end else if (cmd.acc_en) begin
            if (pos_reg < bass_limit) begin
                low_sum_reg <= tbsl_pkg::sat_add(low_sum_reg, s_bar_value);
            end else if (pos_reg < mid_end) begin
                mid_sum_reg <= tbsl_pkg::sat_add(mid_sum_reg, s_bar_value);
            end else begin
                high_sum_reg <= tbsl_pkg::sat_add(high_sum_reg, s_bar_value);
            end
        end
    end

    // operand select for the band under work
    always_comb begin
        case (cmd.band)
            tbsl_pkg::BAND_BASS: begin
                sel_sum = low_sum_reg;
                sel_cnt = bass_cnt;
            end
            tbsl_pkg::BAND_MID: begin
                sel_sum = mid_sum_reg;
                sel_cnt = mid_cnt;
            end
            default: begin
                sel_sum = high_sum_reg;
                sel_cnt = treble_cnt;
            end
        endcase
    end

    // restoring divider, one quotient bit a cycle
    assign div_trial = {drem_reg, quo_reg[tbsl_pkg::SUM_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg  <= sel_sum;
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            if (div_trial >= {1'b0, sel_cnt}) begin
                drem_reg <= tbsl_pkg::CNT_W'(div_trial - {1'b0, sel_cnt});
                quo_reg  <= {quo_reg[tbsl_pkg::SUM_W-2:0], 1'b1};
            end else begin
                drem_reg <= div_trial[tbsl_pkg::CNT_W-1:0];
                quo_reg  <= {quo_reg[tbsl_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    // square root of the mean in q.12, one root bit a cycle
    assign sqrt_cur   = {srem_reg, rad_reg[tbsl_pkg::RAD_W-1 -: 2]};
    assign sqrt_trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_load) begin
            rad_reg  <= {quo_reg, 12'd0};
            root_reg <= '0;
            srem_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[tbsl_pkg::RAD_W-3:0], 2'b00};
            if (sqrt_cur >= sqrt_trial) begin
                srem_reg <= tbsl_pkg::SREM_W'(sqrt_cur - sqrt_trial);
                root_reg <= {root_reg[tbsl_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= sqrt_cur[tbsl_pkg::SREM_W-1:0];
                root_reg <= {root_reg[tbsl_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // gain of 1.2 for bass or 1.1 for mid, floor divide by ten through the reciprocal, saturate; treble is not scaled
    always_comb begin
        if (root_reg >= tbsl_pkg::ROOT_W'(tbsl_pkg::LEVEL_ONE)) begin
            root_sat = tbsl_pkg::LEVEL_ONE;
        end else begin
            root_sat = root_reg[tbsl_pkg::LEVEL_W-1:0];
        end
        case (cmd.band)
            tbsl_pkg::BAND_BASS: gain_prod = {root_sat, 3'b000} + {1'b0, root_sat, 2'b00};
            tbsl_pkg::BAND_MID:  gain_prod = {root_sat, 3'b000} + {2'b00, root_sat, 1'b0}
                                            + {3'b000, root_sat};
            default:             gain_prod = '0;
        endcase
        tenth_prod = 32'(gain_prod) * 32'(tbsl_pkg::RECIP10);
        scaled     = tenth_prod[31:19];
        if (cmd.band == tbsl_pkg::BAND_TREBLE) begin
            level = root_sat;
        end else if (scaled > tbsl_pkg::LEVEL_ONE) begin
            level = tbsl_pkg::LEVEL_ONE;
        end else begin
            level = scaled;
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.scale_en) begin
            case (cmd.band)
                tbsl_pkg::BAND_BASS: m_bass_level   <= level;
                tbsl_pkg::BAND_MID:  m_mid_level    <= level;
                default:             m_treble_level <= level;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/three_band_spectrum_level_unit.sv
// three_band_spectrum_level_unit: top level, controller plus datapath
// depends on tbsl_pkg, tbsl_ctrl, tbsl_datapath
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_bar_value  (16 b, Q4.12)
//  m_        out        m_valid/m_ready    m_bass_level, m_mid_level, m_treble_level (13 b, Q1.12)
//  cfg_      in         cfg_wr_en          cfg_wr_data  (9 b, bar count)
//
// bars are taken one a cycle while s_ready is high; the last bar of a frame starts the shared
// divide and root unit, which works through the bands in turn (a load, 24 divide
// steps, a load, 18 root steps and a scale step per band) with s_ready low
// the result sits in the output register until taken; bars of the next frame
// are taken meanwhile, only its last bar waits for the result to go
// reset is synchronous, active low, and clears the bar count to 24 and the sums
`default_nettype none

module three_band_spectrum_level_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tbsl_pkg::BAR_W-1:0]        cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [tbsl_pkg::SAMPLE_W-1:0]     s_bar_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tbsl_pkg::LEVEL_W-1:0]           m_bass_level,
    output logic [tbsl_pkg::LEVEL_W-1:0]           m_mid_level,
    output logic [tbsl_pkg::LEVEL_W-1:0]           m_treble_level
);

    tbsl_pkg::cmd_t    cmd;
    tbsl_pkg::status_t status;

    // sequencer
    tbsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // sums, divider, root and result registers
    tbsl_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_bar_value    (s_bar_value),
        .cmd            (cmd),
        .status         (status),
        .m_bass_level   (m_bass_level),
        .m_mid_level    (m_mid_level),
        .m_treble_level (m_treble_level)
    );

endmodule

`default_nettype wire

// File: rtl/tbsl_checker.sv
// tbsl_checker: port level checks on the bar and result channels of the unit,
// bound to three_band_spectrum_level_unit
// depends on tbsl_pkg
`default_nettype none

module tbsl_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [tbsl_pkg::LEVEL_W-1:0]  m_bass_level,
    input wire logic [tbsl_pkg::LEVEL_W-1:0]  m_mid_level,
    input wire logic [tbsl_pkg::LEVEL_W-1:0]  m_treble_level
);

    // a stalled result transaction holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bass_level)
                                && $stable(m_mid_level) && $stable(m_treble_level))
        else $error("result changed while stalled");

    // levels never pass 1.0
    a_level_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bass_level <= tbsl_pkg::LEVEL_ONE
                    && m_mid_level <= tbsl_pkg::LEVEL_ONE
                    && m_treble_level <= tbsl_pkg::LEVEL_ONE)
        else $error("level above 1.0");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a new result only comes out of the compute pass, when no bar is taken
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a compute pass");

    // a bar transaction never gives a result in the very next cycle
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result one cycle after a bar");

endmodule

bind three_band_spectrum_level_unit tbsl_checker u_tbsl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_bass_level   (m_bass_level),
    .m_mid_level    (m_mid_level),
    .m_treble_level (m_treble_level)
);

`default_nettype wire

// File: dv/three_band_spectrum_level_unit_tb.sv
// three_band_spectrum_level_unit_tb: self-checking bench for the three band level unit
// directed table then random frames, scored against an in-bench band level predictor
// depends on tbsl_pkg and three_band_spectrum_level_unit
module three_band_spectrum_level_unit_tb;
    import tbsl_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 160;      // outlasts the divide and root pass
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [LEVEL_W-1:0] bass;
        logic [LEVEL_W-1:0] mid;
        logic [LEVEL_W-1:0] treble;
    } levels_t;

    typedef enum logic {
        ROW_CFG,
        ROW_BAR
    } row_kind_t;

    // one row of directed stimulus; want is only used when typed is set
    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
        logic [8:0]          reps;
        logic                typed;
        levels_t             want;
    } stim_row_t;

    localparam int NUM_ROWS = 17;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [BAR_W-1:0]    cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_bar_value = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [LEVEL_W-1:0]  m_bass_level;
    logic [LEVEL_W-1:0]  m_mid_level;
    logic [LEVEL_W-1:0]  m_treble_level;

    // predictor state
    logic [BAR_W-1:0]    bar_count_now = BAR_COUNT_RESET;
    int unsigned         bar_pos       = 0;
    logic [SUM_W-1:0]    band_sum [3]  = '{default: '0};
    levels_t             pending_levels [$];

    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         mismatches    = 0;
    int unsigned         cycle_count   = 0;

    // bar counts per random segment; the last of each group of four is drawn at random
    int unsigned bar_count_plan [12] = '{3, 256, 24, 0, 0, 511, 5, 0, 2, 257, 7, 0};

    stim_row_t directed_rows [NUM_ROWS] = '{
        // reset bar count 24, ten bars, then a cut to 9 ends the frame on the next bar
        '{ROW_BAR, 16'hAAAA, 9'd5, 1'b0, '0},
        '{ROW_BAR, 16'h5555, 9'd5, 1'b0, '0},
        '{ROW_CFG, 16'd9,    9'd1, 1'b0, '0},
        '{ROW_BAR, 16'hFFFF, 9'd1, 1'b0, '0},
        // smallest frame, one bar per band
        '{ROW_CFG, 16'd3,    9'd1, 1'b0, '0},
        '{ROW_BAR, 16'h0000, 9'd3, 1'b1, '{13'd0, 13'd0, 13'd0}},
        '{ROW_BAR, 16'hFFFF, 9'd3, 1'b1, '{13'd4096, 13'd4096, 13'd4096}},
        '{ROW_BAR, 16'hFFFF, 9'd1, 1'b0, '0},
        '{ROW_BAR, 16'h0000, 9'd1, 1'b0, '0},
        '{ROW_BAR, 16'h0001, 9'd1, 1'b1, '{13'd4096, 13'd0, 13'd64}},
        '{ROW_BAR, 16'h0001, 9'd3, 1'b1, '{13'd76, 13'd70, 13'd64}},
        // bar count below the minimum acts as 3
        '{ROW_CFG, 16'd0,    9'd1, 1'b0, '0},
        '{ROW_BAR, 16'h1000, 9'd3, 1'b1, '{13'd4096, 13'd4096, 13'd4096}},
        '{ROW_CFG, 16'd2,    9'd1, 1'b0, '0},
        '{ROW_BAR, 16'h8000, 9'd1, 1'b0, '0},
        '{ROW_BAR, 16'h7FFF, 9'd1, 1'b0, '0},
        '{ROW_BAR, 16'h0100, 9'd1, 1'b0, '0}
    };

    three_band_spectrum_level_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_bar_value    (s_bar_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bass_level   (m_bass_level),
        .m_mid_level    (m_mid_level),
        .m_treble_level (m_treble_level)
    );

    // clock, period 4
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // floor(sqrt(mean * 4096)), bit by bit from the top of the root
    function automatic longint unsigned root_q12(input longint unsigned mean);
        longint unsigned rad;
        longint unsigned r;
        longint unsigned trial;
        rad = mean << 12;
        r   = 0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= rad)
                r = trial;
        end
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_sat(input longint unsigned x);
        return (x > LEVEL_ONE) ? LEVEL_ONE : x[LEVEL_W-1:0];
    endfunction

    // add one accepted bar to its band and queue the levels when the frame closes
    task automatic fold_bar(input logic [SAMPLE_W-1:0] v, input logic typed,
                            input levels_t typed_levels);
        int unsigned     n;
        int unsigned     bass_limit;
        int unsigned     mid_end;
        band_t           band;
        logic [SUM_W:0]  total;
        longint unsigned root_b;
        longint unsigned root_m;
        longint unsigned root_t;
        levels_t         lv;
        n = bar_count_now;
        if (n < MIN_BARS)
            n = MIN_BARS;
        if (n > MAX_BARS)
            n = MAX_BARS;
        bass_limit = n / 3;
        mid_end    = (2 * n) / 3;
        if (bar_pos < bass_limit)
            band = BAND_BASS;
        else if (bar_pos < mid_end)
            band = BAND_MID;
        else
            band = BAND_TREBLE;
        total = {1'b0, band_sum[band]} + (SUM_W+1)'(v);
        band_sum[band] = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
        if (bar_pos + 1 < n) begin
            bar_pos++;
        end else begin
            root_b    = root_q12(band_sum[BAND_BASS] / bass_limit);
            root_m    = root_q12(band_sum[BAND_MID] / (mid_end - bass_limit));
            root_t    = root_q12(band_sum[BAND_TREBLE] / (n - mid_end));
            lv.bass   = level_sat((root_b * 12) / 10);
            lv.mid    = level_sat((root_m * 11) / 10);
            lv.treble = level_sat(root_t);
            pending_levels.push_back(typed ? typed_levels : lv);
            bar_pos  = 0;
            band_sum = '{default: '0};
        end
    endtask

    // offer one bar, with random gaps, and hold it until taken
    task automatic send_bar(input logic [SAMPLE_W-1:0] v, input logic typed,
                            input levels_t typed_levels);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_bar_value <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        fold_bar(v, typed, typed_levels);
    endtask

    // stop sending, wait for every queued level transaction, then let the unit go quiet
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bar_count(input logic [BAR_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en     <= 1'b0;
        bar_count_now  = value;
    endtask

    task automatic check_level(input string field, input logic [LEVEL_W-1:0] want,
                               input logic [LEVEL_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // score each level transaction against the oldest expectation
    always @(posedge aclk) begin
        levels_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                mismatches++;
                $error("level transaction with nothing expected: %0d %0d %0d",
                       m_bass_level, m_mid_level, m_treble_level);
            end else begin
                want = pending_levels.pop_front();
                check_level("bass_level", want.bass, m_bass_level);
                check_level("mid_level", want.mid, m_mid_level);
                check_level("treble_level", want.treble, m_treble_level);
            end
        end
    end

    initial begin
        int unsigned         n_eff;
        int unsigned         frames;
        int unsigned         tail;
        int unsigned         n_items;
        logic [BAR_W-1:0]    cfg_v;
        logic [SAMPLE_W-1:0] v;

        send_idle_pct = 32;
        recv_idle_pct = 80;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_bar_count(directed_rows[r].value[BAR_W-1:0]);
            end else begin
                for (int k = 0; k < directed_rows[r].reps; k++)
                    send_bar(directed_rows[r].value,
                             directed_rows[r].typed && (k == directed_rows[r].reps - 1),
                             directed_rows[r].want);
            end
        end

        // random frames: three idling regimes, four bar counts each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 80;
                end
                1: begin
                    send_idle_pct = 80;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                if (seg == 3)
                    cfg_v = BAR_W'($urandom_range(511, 0));
                else
                    cfg_v = BAR_W'(bar_count_plan[phase * 4 + seg]);
                write_bar_count(cfg_v);
                n_eff = cfg_v;
                if (n_eff < MIN_BARS)
                    n_eff = MIN_BARS;
                if (n_eff > MAX_BARS)
                    n_eff = MAX_BARS;
                // whole frames plus, at random, a partial one left open across the next write
                frames  = (n_eff >= 60) ? 1 : 60 / n_eff;
                tail    = (n_eff - 1 < 20) ? n_eff - 1 : 20;
                n_items = frames * n_eff + $urandom_range(tail, 0);
                repeat (n_items) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: v = SAMPLE_W'($urandom);
                        4, 5:       v = SAMPLE_W'($urandom_range(3000, 0));
                        6:          v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                        7:          v = SAMPLE_W'($urandom_range(4600, 3500));
                        default:    v = SAMPLE_W'($urandom_range(255, 0));
                    endcase
                    send_bar(v, 1'b0, '0);
                end
            end
        end

        settle();
        if (mismatches == 0 && pending_levels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: three_band_spectrum_level_unit.f
rtl/tbsl_pkg.sv
rtl/tbsl_ctrl.sv
rtl/tbsl_datapath.sv
rtl/three_band_spectrum_level_unit.sv
rtl/tbsl_checker.sv
dv/three_band_spectrum_level_unit_tb.sv
